// ----- hw/rtl/fvs_pkg.sv -----
package fvs_pkg;

    // Field format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    // Dividend bits still to be shifted in once the upper part is settled
    localparam int SHIFT_IN   = DATA_WIDTH - FRAC_BITS;
    // One quotient bit per divider stage
    localparam int DIV_STEPS  = DATA_WIDTH;

    localparam logic [31:0] DET_THRESHOLD_RESET = 32'd4295;

    // Differences of products leaving the multiplier stages
    typedef struct packed {
        logic signed [PROD_WIDTH-1:0] det;
        logic signed [PROD_WIDTH-1:0] num_x;
        logic signed [PROD_WIDTH-1:0] num_y;
    } mul_item_t;

    // One quotient lane: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic                  neg;
        logic                  over;
        logic [PROD_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] word;
    } lane_t;

    typedef struct packed {
        logic                  sing;
        logic [PROD_WIDTH-1:0] den;
        lane_t                 x;
        lane_t                 y;
    } div_item_t;

    // Magnitude of a determinant or numerator (never the most negative value)
    function automatic logic [PROD_WIDTH-1:0] mag(input logic signed [PROD_WIDTH-1:0] v);
        logic [PROD_WIDTH-1:0] m;
        m = v[PROD_WIDTH-1] ? PROD_WIDTH'(-v) : PROD_WIDTH'(v);
        return m;
    endfunction

endpackage

// ----- hw/rtl/flow_vector_2x2_solve.sv -----
// 2x2 optical flow solve, one pixel per transaction.
// Input channel s_*: q_x, q_y, c_xx, c_yy, c_xy, signed Q16.16, valid/ready.
// Result channel m_*: flow_x, flow_y (signed Q16.16), singular, clipped.
// cfg_wr_en/cfg_wr_data write det_threshold (|det| limit, Q32.32 units);
// write it only while no transaction is in flight.
// The path runs through 36 register stages: two multiplier stages, one
// magnitude/threshold stage, 32 divider stages (one quotient bit per stage,
// both flow components in parallel) and the output register.
// Throughput: one transaction per cycle unless m_ready holds the output back;
// every stage has its own valid bit.
// Quotients are truncated toward zero and saturated, setting clipped; a
// determinant that is zero or below the threshold gives zero flow with
// singular set.
// Reset (aresetn low, synchronous) empties the pipeline and sets the
// threshold to 4295. When m_ready is low, stages keep filling until every
// stage holds a transaction, then s_ready drops; nothing is lost or repeated.
module flow_vector_2x2_solve (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [31:0]                           cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] s_q_x,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] s_q_y,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] s_c_xx,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] s_c_yy,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] s_c_xy,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fvs_pkg::DATA_WIDTH-1:0] m_flow_x,
    output logic signed [fvs_pkg::DATA_WIDTH-1:0] m_flow_y,
    output logic                                  m_singular,
    output logic                                  m_clipped
);

    logic [31:0]        det_threshold_reg;
    logic               mul_valid, mul_ready, prep_valid, prep_ready, div_valid, div_ready;
    fvs_pkg::mul_item_t mul_item;
    fvs_pkg::div_item_t prep_item, div_item;

    logic                                  valid_reg;
    logic signed [fvs_pkg::DATA_WIDTH-1:0] flow_x_reg, flow_y_reg, flow_x_next, flow_y_next;
    logic                                  singular_reg, clipped_reg, clipped_next;
    logic                                  clip_x, clip_y;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_threshold_reg <= fvs_pkg::DET_THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            det_threshold_reg <= cfg_wr_data;
        end
    end

    fvs_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .q_x       (s_q_x),
        .q_y       (s_q_y),
        .c_xx      (s_c_xx),
        .c_yy      (s_c_yy),
        .c_xy      (s_c_xy),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_item  (mul_item)
    );

    fvs_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .det_threshold (det_threshold_reg),
        .in_valid      (mul_valid),
        .in_ready      (mul_ready),
        .in_item       (mul_item),
        .out_valid     (prep_valid),
        .out_ready     (prep_ready),
        .out_item      (prep_item)
    );

    fvs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_item   (prep_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    // Sign, saturation to the signed range
    function automatic logic [fvs_pkg::DATA_WIDTH:0] finish(input fvs_pkg::lane_t l);
        logic [fvs_pkg::DATA_WIDTH:0]   lim;
        logic [fvs_pkg::DATA_WIDTH:0]   q;
        logic                           over;
        logic [fvs_pkg::DATA_WIDTH-1:0] res;
        lim  = l.neg ? ({{fvs_pkg::DATA_WIDTH{1'b0}}, 1'b1} << (fvs_pkg::DATA_WIDTH - 1))
                     : (({{fvs_pkg::DATA_WIDTH{1'b0}}, 1'b1} << (fvs_pkg::DATA_WIDTH - 1))
                        - 1'b1);
        q    = {1'b0, l.word};
        over = l.over || (q > lim);
        if (over) q = lim;
        res  = l.neg ? fvs_pkg::DATA_WIDTH'(-q) : q[fvs_pkg::DATA_WIDTH-1:0];
        return {over, res};
    endfunction

    always_comb begin
        {clip_x, flow_x_next} = finish(div_item.x);
        {clip_y, flow_y_next} = finish(div_item.y);
        clipped_next = clip_x || clip_y;
        if (div_item.sing) begin
            flow_x_next  = '0;
            flow_y_next  = '0;
            clipped_next = 1'b0;
        end
    end

    // Output register
    assign div_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (div_ready) begin
            valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready) begin
            flow_x_reg   <= flow_x_next;
            flow_y_reg   <= flow_y_next;
            singular_reg <= div_item.sing;
            clipped_reg  <= clipped_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_flow_x   = flow_x_reg;
    assign m_flow_y   = flow_y_reg;
    assign m_singular = singular_reg;
    assign m_clipped  = clipped_reg;

endmodule

// ----- hw/rtl/fvs_mul.sv -----
module fvs_mul (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] q_x,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] q_y,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] c_xx,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] c_yy,
    input  logic signed [fvs_pkg::DATA_WIDTH-1:0] c_xy,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output fvs_pkg::mul_item_t                   out_item
);

    logic signed [fvs_pkg::PROD_WIDTH-1:0] qx_cyy_reg, qy_cxy_reg, qy_cxx_reg;
    logic signed [fvs_pkg::PROD_WIDTH-1:0] qx_cxy_reg, cxx_cyy_reg, cxy_cxy_reg;
    logic                                  prod_valid_reg;
    fvs_pkg::mul_item_t                    diff_reg;
    logic                                  diff_valid_reg;
    logic                                  diff_adv, prod_adv;

    // Stage advance chain
    assign diff_adv  = !diff_valid_reg || out_ready;
    assign prod_adv  = !prod_valid_reg || diff_adv;
    assign in_ready  = prod_adv;
    assign out_valid = diff_valid_reg;
    assign out_item  = diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            diff_valid_reg <= 1'b0;
        end else begin
            if (prod_adv) prod_valid_reg <= in_valid;
            if (diff_adv) diff_valid_reg <= prod_valid_reg;
        end
    end

    // Six products, one multiplier each
    always_ff @(posedge aclk) begin
        if (prod_adv) begin
            qx_cyy_reg  <= q_x * c_yy;
            qy_cxy_reg  <= q_y * c_xy;
            qy_cxx_reg  <= q_y * c_xx;
            qx_cxy_reg  <= q_x * c_xy;
            cxx_cyy_reg <= c_xx * c_yy;
            cxy_cxy_reg <= c_xy * c_xy;
        end
    end

    // Determinant and Cramer numerators
    always_ff @(posedge aclk) begin
        if (diff_adv) begin
            diff_reg.det   <= cxx_cyy_reg - cxy_cxy_reg;
            diff_reg.num_x <= qx_cyy_reg - qy_cxy_reg;
            diff_reg.num_y <= qy_cxx_reg - qx_cxy_reg;
        end
    end

endmodule

// ----- hw/rtl/fvs_prep.sv -----
module fvs_prep (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [31:0]        det_threshold,
    input  logic               in_valid,
    output logic               in_ready,
    input  fvs_pkg::mul_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output fvs_pkg::div_item_t out_item
);

    logic               valid_reg;
    fvs_pkg::div_item_t item_reg;
    fvs_pkg::div_item_t item_next;
    logic               adv;
    logic [fvs_pkg::PROD_WIDTH-1:0] adet;

    assign adv       = !valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    function automatic fvs_pkg::lane_t lane_init(
        input logic signed [fvs_pkg::PROD_WIDTH-1:0] num,
        input logic signed [fvs_pkg::PROD_WIDTH-1:0] den,
        input logic [fvs_pkg::PROD_WIDTH-1:0]        d
    );
        fvs_pkg::lane_t l;
        logic [fvs_pkg::PROD_WIDTH-1:0] n;
        n = fvs_pkg::mag(num);
        l.neg  = num[fvs_pkg::PROD_WIDTH-1] ^ den[fvs_pkg::PROD_WIDTH-1];
        // Quotient would need more than DATA_WIDTH bits
        l.over = {{fvs_pkg::SHIFT_IN{1'b0}}, n} >= {d, {fvs_pkg::SHIFT_IN{1'b0}}};
        l.rem  = n >> fvs_pkg::SHIFT_IN;
        l.word = {n[fvs_pkg::SHIFT_IN-1:0], {fvs_pkg::FRAC_BITS{1'b0}}};
        return l;
    endfunction

    // Magnitudes, singular test, upper-quotient overflow test
    always_comb begin
        adet           = fvs_pkg::mag(in_item.det);
        item_next.den  = adet;
        item_next.sing = (in_item.det == '0) ||
                         (adet < {{(fvs_pkg::PROD_WIDTH-32){1'b0}}, det_threshold});
        item_next.x    = lane_init(in_item.num_x, in_item.det, adet);
        item_next.y    = lane_init(in_item.num_y, in_item.det, adet);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) item_reg <= item_next;
    end

endmodule

// ----- hw/rtl/fvs_div.sv -----
module fvs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fvs_pkg::div_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output fvs_pkg::div_item_t out_item
);

    fvs_pkg::div_item_t              stage_reg [fvs_pkg::DIV_STEPS];
    fvs_pkg::div_item_t              stage_next [fvs_pkg::DIV_STEPS];
    logic [fvs_pkg::DIV_STEPS-1:0]   valid_reg;
    logic [fvs_pkg::DIV_STEPS-1:0]   adv;

    // One restoring step: shift in a dividend bit, trial subtract
    function automatic fvs_pkg::lane_t lane_step(
        input fvs_pkg::lane_t l,
        input logic [fvs_pkg::PROD_WIDTH-1:0] d
    );
        fvs_pkg::lane_t o;
        logic [fvs_pkg::PROD_WIDTH:0] rs;
        logic qbit;
        rs   = {l.rem, l.word[fvs_pkg::DATA_WIDTH-1]};
        qbit = rs >= {1'b0, d};
        if (qbit) rs = rs - {1'b0, d};
        o.neg  = l.neg;
        o.over = l.over;
        o.rem  = rs[fvs_pkg::PROD_WIDTH-1:0];
        o.word = {l.word[fvs_pkg::DATA_WIDTH-2:0], qbit};
        return o;
    endfunction

    function automatic fvs_pkg::div_item_t item_step(input fvs_pkg::div_item_t a);
        fvs_pkg::div_item_t o;
        o.sing = a.sing;
        o.den  = a.den;
        o.x    = lane_step(a.x, a.den);
        o.y    = lane_step(a.y, a.den);
        return o;
    endfunction

    // Advance chain from the output back
    always_comb begin
        adv[fvs_pkg::DIV_STEPS-1] = !valid_reg[fvs_pkg::DIV_STEPS-1] || out_ready;
        for (int k = fvs_pkg::DIV_STEPS - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb begin
        stage_next[0] = item_step(in_item);
        for (int k = 1; k < fvs_pkg::DIV_STEPS; k++) begin
            stage_next[k] = item_step(stage_reg[k-1]);
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[fvs_pkg::DIV_STEPS-1];
    assign out_item  = stage_reg[fvs_pkg::DIV_STEPS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) valid_reg[0] <= in_valid;
            for (int k = 1; k < fvs_pkg::DIV_STEPS; k++) begin
                if (adv[k]) valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < fvs_pkg::DIV_STEPS; k++) begin
            if (adv[k]) stage_reg[k] <= stage_next[k];
        end
    end

endmodule

// ----- tb/flow_vector_2x2_solve_tb.sv -----
`timescale 1ns / 100ps

module flow_vector_2x2_solve_tb;

    localparam int LATENCY = 36;

    typedef struct {
        logic signed [fvs_pkg::DATA_WIDTH-1:0] q_x, q_y, c_xx, c_yy, c_xy;
    } pixel_t;

    typedef struct {
        logic signed [fvs_pkg::DATA_WIDTH-1:0] flow_x, flow_y;
        logic                                  singular, clipped;
    } flow_t;

    typedef enum int {IDLE_SEND_HEAVY, IDLE_RECV_HEAVY, IDLE_NONE} idle_mode_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  cfg_wr_en = 1'b0;
    logic [31:0]                           cfg_wr_data = '0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic signed [fvs_pkg::DATA_WIDTH-1:0] s_q_x = '0, s_q_y = '0;
    logic signed [fvs_pkg::DATA_WIDTH-1:0] s_c_xx = '0, s_c_yy = '0, s_c_xy = '0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic signed [fvs_pkg::DATA_WIDTH-1:0] m_flow_x, m_flow_y;
    logic                                  m_singular, m_clipped;

    pixel_t     pixel_queue[$];
    flow_t      flow_expected[$];
    logic [31:0] threshold = fvs_pkg::DET_THRESHOLD_RESET;
    idle_mode_t idle_mode = IDLE_SEND_HEAVY;
    int         hold_cycles = 0;
    int         fail_count = 0;
    int         accepted = 0;
    int         pushed = 0;

    flow_vector_2x2_solve uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_q_x(s_q_x), .s_q_y(s_q_y), .s_c_xx(s_c_xx), .s_c_yy(s_c_yy), .s_c_xy(s_c_xy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_flow_x(m_flow_x), .m_flow_y(m_flow_y),
        .m_singular(m_singular), .m_clipped(m_clipped)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // (num << FRAC_BITS) / den, truncated toward zero, saturated
    function automatic logic signed [fvs_pkg::DATA_WIDTH-1:0] flow_quotient(
        input logic signed [127:0] num, input logic signed [127:0] den, inout logic clip);
        logic signed [127:0] q;
        logic signed [127:0] hi_lim, lo_lim;
        hi_lim = (128'sd1 <<< (fvs_pkg::DATA_WIDTH - 1)) - 1;
        lo_lim = -(128'sd1 <<< (fvs_pkg::DATA_WIDTH - 1));
        q = (num <<< fvs_pkg::FRAC_BITS) / den;
        if (q > hi_lim) begin
            clip = 1'b1;
            q = hi_lim;
        end else if (q < lo_lim) begin
            clip = 1'b1;
            q = lo_lim;
        end
        return q[fvs_pkg::DATA_WIDTH-1:0];
    endfunction

    function automatic flow_t solve_pixel(input pixel_t p, input logic [31:0] thr);
        logic signed [127:0] qx, qy, cxx, cyy, cxy, det, adet;
        flow_t r;
        logic clip;
        qx = p.q_x; qy = p.q_y; cxx = p.c_xx; cyy = p.c_yy; cxy = p.c_xy;
        det = cxx * cyy - cxy * cxy;
        adet = det < 0 ? -det : det;
        clip = 1'b0;
        r.flow_x = '0;
        r.flow_y = '0;
        r.singular = 1'b1;
        r.clipped = 1'b0;
        if (det != 0 && adet >= {96'd0, thr}) begin
            r.flow_x = flow_quotient(qx * cyy - qy * cxy, det, clip);
            r.flow_y = flow_quotient(qy * cxx - qx * cxy, det, clip);
            r.singular = 1'b0;
            r.clipped = clip;
        end
        return r;
    endfunction

    // Field values: mostly moderate tensors so that solves are well conditioned
    function automatic logic signed [fvs_pkg::DATA_WIDTH-1:0] rand_field(input bit tensor);
        case ($urandom_range(9))
            0: return $urandom;
            1: return $signed(32'h8000_0000);
            2: return 32'sh7FFF_FFFF;
            3: return $signed($urandom_range(255)) - 128;
            default:
                if (tensor) return $signed($urandom_range(32'h0008_0000, 32'h0000_1000));
                else return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    task automatic add_pixel(input logic signed [fvs_pkg::DATA_WIDTH-1:0] qx, qy, cxx, cyy,
                             cxy);
        pixel_t p;
        p.q_x = qx; p.q_y = qy; p.c_xx = cxx; p.c_yy = cyy; p.c_xy = cxy;
        pixel_queue.push_back(p);
        pushed++;
    endtask

    task automatic add_random(input int count);
        logic signed [fvs_pkg::DATA_WIDTH-1:0] cxx, cyy;
        repeat (count) begin
            cxx = rand_field(1);
            cyy = rand_field(1);
            // some near-singular tensors: c_xy close to sqrt(cxx*cyy)
            if ($urandom_range(7) == 0)
                add_pixel(rand_field(0), rand_field(0), cxx, cxx, cxx + $signed($urandom_range(3)));
            else
                add_pixel(rand_field(0), rand_field(0), cxx, cyy,
                          ($urandom_range(3) == 0) ? rand_field(0) : rand_field(1) >>> 2);
        end
    endtask

    task automatic wait_drained();
        while (accepted < pushed || flow_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        threshold = value;
    endtask

    // Sender: takes the next pixel from the queue, holds it until accepted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                flow_expected.push_back(solve_pixel('{s_q_x, s_q_y, s_c_xx, s_c_yy, s_c_xy},
                                                    threshold));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 &&
                    $urandom_range(99) >= (idle_mode == IDLE_SEND_HEAVY ? 31 :
                                           idle_mode == IDLE_RECV_HEAVY ? 53 : 0)) begin
                    pixel_t p;
                    p = pixel_queue.pop_front();
                    s_valid <= 1'b1;
                    s_q_x <= p.q_x; s_q_y <= p.q_y;
                    s_c_xx <= p.c_xx; s_c_yy <= p.c_yy; s_c_xy <= p.c_xy;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern, with an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= (idle_mode == IDLE_SEND_HEAVY ? 53 :
                                              idle_mode == IDLE_RECV_HEAVY ? 31 : 0);
        end
    end

    // Monitor: compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (flow_expected.size() == 0) begin
                $display("%0t: unexpected result flow_x=%h flow_y=%h", $time, m_flow_x, m_flow_y);
                fail_count++;
            end else begin
                flow_t e;
                e = flow_expected.pop_front();
                if (m_flow_x !== e.flow_x) begin
                    $display("%0t: flow_x expected %h actual %h", $time, e.flow_x, m_flow_x);
                    fail_count++;
                end
                if (m_flow_y !== e.flow_y) begin
                    $display("%0t: flow_y expected %h actual %h", $time, e.flow_y, m_flow_y);
                    fail_count++;
                end
                if (m_singular !== e.singular) begin
                    $display("%0t: singular expected %b actual %b", $time, e.singular, m_singular);
                    fail_count++;
                end
                if (m_clipped !== e.clipped) begin
                    $display("%0t: clipped expected %b actual %b", $time, e.clipped, m_clipped);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, extremes, singular, clipping, zero det at the reset threshold
        add_pixel(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
        add_pixel(32'sh7FFF_FFFF, $signed(32'h8000_0000), 32'sh0000_0001, 32'sh0000_0001, 0);
        add_pixel($signed(32'h8000_0000), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  $signed(32'h8000_0000));
        add_pixel($signed(32'h8000_0000), $signed(32'h8000_0000), $signed(32'h8000_0000),
                  $signed(32'h8000_0000), 32'sh7FFF_FFFF);
        add_pixel(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        add_pixel(32'sh1234_5678, -32'sh0765_4321, 32'sh0000_0040, 32'sh0000_0042, 32'sh0000_0041);
        add_pixel(-32'sh0003_0000, 32'sh0005_8000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0000_8000);
        add_pixel(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001, $signed(32'h8000_0000), 0);
        add_pixel(-1, -1, -1, -1, -1);
        add_pixel(0, 0, 32'sh0000_0002, 32'sh0000_0002, 32'sh0000_0001);
        add_pixel(32'shFFFF_0000, 32'sh0000_FFFF, 32'sh0000_0003, 32'sh0000_0005, 32'sh0000_0002);
        add_random(400);
        wait_drained();

        // zero threshold: only an exactly zero determinant is singular
        idle_mode = IDLE_RECV_HEAVY;
        write_threshold(32'd0);
        add_pixel(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        add_pixel(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_0001, 32'sh0000_0001, 0);
        add_random(400);
        wait_drained();

        // full threshold, with a long receiver hold-off so the pipeline backs up
        idle_mode = IDLE_NONE;
        write_threshold(32'hFFFF_FFFF);
        hold_cycles = 200;
        add_random(250);
        wait_drained();

        write_threshold(32'h0001_0000 + $urandom_range(32'h00FF_FFFF));
        add_random(150);
        wait_drained();

        if (fail_count == 0 && flow_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
